// ===== design/psc_pkg.sv =====
package psc_pkg;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_STAMP = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [2:0] CSR_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_SCALE  = 3'd2;
   localparam logic [2:0] CSR_RED    = 3'd3;
   localparam logic [2:0] CSR_GREEN  = 3'd4;
   localparam logic [2:0] CSR_BLUE   = 3'd5;
   localparam logic [2:0] CSR_BACK   = 3'd6;

   localparam int NUM_CLASS = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_STAMP_RD,
      ST_STAMP_WAIT,
      ST_STAMP_WR,
      ST_READ_WAIT,
      ST_READ_OUT
   } state_type;

   // Weight 9'h100 is full weight, zero is absent.
   function automatic logic [8:0] fp_weight(input logic [3:0] sel, input logic [3:0] cls);
      logic [8:0] w;
      w = 9'd0;
      unique case (sel)
         4'd0: w = (cls == 4'd0) ? 9'd256 : 9'd0;
         4'd1: w = (cls == 4'd0) ? 9'd256 : (cls == 4'd1) ? 9'd64 : 9'd0;
         4'd2: w = (cls == 4'd0) ? 9'd256 : (cls == 4'd1) ? 9'd128 : 9'd0;
         4'd3, 4'd6: w = (cls <= 4'd1) ? 9'd256 : 9'd0;
         4'd4: begin
            case (cls)
               4'd0, 4'd1: w = 9'd256;
               4'd2: w = 9'd128;
               4'd3: w = 9'd96;
               default: w = 9'd0;
            endcase
         end
         4'd5: begin
            case (cls)
               4'd0, 4'd1, 4'd2: w = 9'd256;
               4'd3: w = 9'd180;
               4'd4: w = 9'd128;
               4'd5: w = 9'd64;
               default: w = 9'd0;
            endcase
         end
         4'd7: w = (cls <= 4'd1) ? 9'd256 : (cls == 4'd2) ? 9'd96 : 9'd0;
         4'd8: w = (cls <= 4'd1) ? 9'd256 : (cls == 4'd2) ? 9'd160 : 9'd0;
         4'd9: w = (cls <= 4'd2) ? 9'd256 : (cls == 4'd3) ? 9'd128 : 9'd0;
         4'd10: begin
            case (cls)
               4'd0, 4'd1, 4'd2: w = 9'd256;
               4'd3: w = 9'd200;
               4'd4: w = 9'd160;
               4'd5: w = 9'd96;
               default: w = 9'd0;
            endcase
         end
         4'd11: begin
            case (cls)
               4'd0, 4'd1, 4'd2, 4'd3: w = 9'd256;
               4'd6: w = 9'd180;
               4'd7: w = 9'd128;
               4'd8: w = 9'd96;
               4'd9: w = 9'd48;
               default: w = 9'd0;
            endcase
         end
         default: w = 9'd0;
      endcase
      return w;
   endfunction

   function automatic logic [1:0] cls_a(input logic [3:0] cls);
      case (cls)
         4'd0: return 2'd0;
         4'd1, 4'd2: return 2'd1;
         4'd3, 4'd4, 4'd5: return 2'd2;
         default: return 2'd3;
      endcase
   endfunction

   function automatic logic [1:0] cls_b(input logic [3:0] cls);
      case (cls)
         4'd2, 4'd4, 4'd7: return 2'd1;
         4'd5, 4'd8: return 2'd2;
         4'd9: return 2'd3;
         default: return 2'd0;
      endcase
   endfunction

endpackage

// ===== design/psc_ram.sv =====
module psc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/psc_blend.sv =====
// Weighting and source-over blend of one pixel, two stages split by a register.
// Stage one applies the footprint weight; stage two blends with the frame word.
module psc_blend import psc_pkg::*; (
   input  logic        clock,
   input  logic [8:0]  weight,
   input  logic [7:0]  src_a,
   input  logic [7:0]  src_r,
   input  logic [7:0]  src_g,
   input  logic [7:0]  src_b,
   input  logic [31:0] dest,
   output logic [31:0] result
);
   logic [7:0]  wa, wr, wg, wb;
   logic [7:0]  ws_ff [4];
   logic        full_ff;
   logic [31:0] res;
   logic [7:0]  inv;
   logic [15:0] prod;
   logic [31:0] scaled;

   always_comb begin
      if (weight[8]) begin
         wa = src_a; wr = src_r; wg = src_g; wb = src_b;
      end else begin
         wa = 8'((16'(src_a) * 16'(weight[7:0])) >> 8);
         wr = 8'((16'(src_r) * 16'(weight[7:0])) >> 8);
         wg = 8'((16'(src_g) * 16'(weight[7:0])) >> 8);
         wb = 8'((16'(src_b) * 16'(weight[7:0])) >> 8);
      end
   end

   always_ff @(posedge clock) begin
      ws_ff[3] <= wa;
      ws_ff[2] <= wr;
      ws_ff[1] <= wg;
      ws_ff[0] <= wb;
      full_ff  <= weight[8];
   end

   always_comb begin
      inv = 8'd255 - ws_ff[3];
      res = {ws_ff[3], ws_ff[2], ws_ff[1], ws_ff[0]};
      prod = '0;
      scaled = '0;
      if (full_ff && ws_ff[3] == 8'd255) begin
         res = {ws_ff[3], ws_ff[2], ws_ff[1], ws_ff[0]};
      end else if (ws_ff[3] == 8'd0) begin
         res = dest;
      end else if (dest != 32'd0) begin
         for (int i = 0; i < 4; i++) begin
            prod = 16'(dest[8*i +: 8]) * 16'(inv);
            scaled = 32'(prod) * 32'h8081;
            res[8*i +: 8] = ws_ff[i] + scaled[30:23];
         end
      end
   end

   assign result = res;
endmodule

// ===== design/particle_sprite_compositor.sv =====
// A read is busy in its wait and output states; its result strobe is high in the output state.
// A stamp walks all 49 footprint slots: an absent or clipped slot passes only the read state,
// a drawn pixel goes through read, wait and write (at most 37 drawn, 12 skipped). A clear
// writes all width*height words. One operation at a time; busy is high until it is done.
// The single frame memory port pair sets the rate. The receiver cannot stall.
// Reset returns the state and configuration registers to defaults; the frame is undefined.
module particle_sprite_compositor import psc_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_x_pos,
   input  logic [7:0]  req_y_pos,
   input  logic        req_large_dot,
   input  logic [7:0]  req_opacity,
   output logic        rsp_valid,
   output logic [31:0] rsp_pixel_word,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);

   // Configuration registers.
   logic [8:0]  width_ff, height_ff;
   logic [2:0]  scale_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [31:0] back_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256; height_ff <= 9'd256; scale_ff <= '0;
         red_ff <= 8'd255; green_ff <= 8'd255; blue_ff <= 8'd255; back_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data[8:0];
            CSR_HEIGHT: height_ff <= csr_data[8:0];
            CSR_SCALE:  scale_ff  <= csr_data[2:0];
            CSR_RED:    red_ff    <= csr_data[7:0];
            CSR_GREEN:  green_ff  <= csr_data[7:0];
            CSR_BLUE:   blue_ff   <= csr_data[7:0];
            CSR_BACK:   back_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective frame size, saturated at the memory dimensions.
   logic [XW+8:0] wd;
   logic [YW+8:0] ht;
   assign wd = (width_ff > 9'(MAX_WIDTH < 511 ? MAX_WIDTH : 511))
             ? (XW+9)'(MAX_WIDTH) : (XW+9)'(width_ff);
   assign ht = (height_ff > 9'(MAX_HEIGHT < 511 ? MAX_HEIGHT : 511))
             ? (YW+9)'(MAX_HEIGHT) : (YW+9)'(height_ff);

   state_type state_ff, state_in;

   // Per-operation registers.
   logic [7:0]  cx_ff, cy_ff, sa_ff, sr_ff, sg_ff, sb_ff;
   logic [3:0]  sel_ff;
   logic [3:0]  cls_ff, cls_in;
   logic [2:0]  pt_ff, pt_in;
   logic [AW:0] clr_ff, clr_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [31:0] rdpix_ff;
   logic        oob_ff, oob_in;

   // Footprint point of the current class and index.
   logic [1:0]  a, b;
   logic [8:0]  w;
   logic [2:0]  npts;
   logic signed [10:0] dx, dy, px, py;
   logic        in_frame;
   logic [AW+10:0] lin;
   always_comb begin
      a = cls_a(cls_ff);
      b = cls_b(cls_ff);
      w = fp_weight(sel_ff, cls_ff);
      npts = (a == 2'd0) ? 3'd0 : (b == 2'd0 || a == b) ? 3'd3 : 3'd7;
      dx = '0; dy = '0;
      if (a != 2'd0 && b == 2'd0) begin
         case (pt_ff[1:0])
            2'd0: begin dx = -11'(a); dy = '0; end
            2'd1: begin dx = 11'(a); dy = '0; end
            2'd2: begin dx = '0; dy = -11'(a); end
            default: begin dx = '0; dy = 11'(a); end
         endcase
      end else if (a != 2'd0) begin
         case (pt_ff)
            3'd0: begin dx = -11'(a); dy = -11'(b); end
            3'd1: begin dx = 11'(a);  dy = -11'(b); end
            3'd2: begin dx = -11'(a); dy = 11'(b); end
            3'd3: begin dx = 11'(a);  dy = 11'(b); end
            3'd4: begin dx = -11'(b); dy = -11'(a); end
            3'd5: begin dx = 11'(b);  dy = -11'(a); end
            3'd6: begin dx = -11'(b); dy = 11'(a); end
            default: begin dx = 11'(b); dy = 11'(a); end
         endcase
      end
      px = 11'(cx_ff) + dx;
      py = 11'(cy_ff) + dy;
      in_frame = !px[10] && !py[10] && (32'(px) < 32'(wd)) && (32'(py) < 32'(ht));
      lin = (AW+11)'(py[9:0]) * (AW+11)'(wd) + (AW+11)'(px[9:0]);
   end

   // Frame memory with a single write and a single read port.
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata, mem_rdata, blend_out;

   psc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata)
   );

   // Weight is applied in the cycle the address goes out; blending follows.
   psc_blend u_blend (
      .clock(clock), .weight(w), .src_a(sa_ff), .src_r(sr_ff), .src_g(sg_ff),
      .src_b(sb_ff), .dest(mem_rdata), .result(blend_out)
   );

   logic [AW-1:0] rd_lin;
   logic [AW+10:0] rd_full;
   assign rd_full = (AW+11)'(req_y_pos) * (AW+11)'(wd) + (AW+11)'(req_x_pos);
   assign rd_lin = rd_full[AW-1:0];

   logic skip;
   assign skip = (w == 9'd0) || !in_frame;

   always_comb begin
      state_in = state_ff;
      cls_in = cls_ff; pt_in = pt_ff; clr_in = clr_ff;
      addr_in = addr_ff; oob_in = oob_ff;
      mem_we = 1'b0; mem_waddr = addr_ff; mem_wdata = blend_out;
      mem_raddr = lin[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = rd_lin;
            if (start) begin
               unique case (req_operation)
                  OP_CLEAR: begin
                     clr_in = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_STAMP: begin
                     cls_in = '0; pt_in = '0;
                     state_in = (scale_ff > 3'd5) ? ST_IDLE : ST_STAMP_RD;
                  end
                  OP_READ: begin
                     oob_in = !(32'(req_x_pos) < 32'(wd) && 32'(req_y_pos) < 32'(ht));
                     state_in = ST_READ_WAIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (32'(clr_ff) >= 32'(wd) * 32'(ht)) begin
               state_in = ST_IDLE;
            end else begin
               mem_we = 1'b1;
               mem_waddr = clr_ff[AW-1:0];
               mem_wdata = back_ff;
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_STAMP_RD: begin
            addr_in = lin[AW-1:0];
            if (skip) begin
               if (pt_ff >= npts) begin
                  pt_in = '0;
                  if (32'(cls_ff) == NUM_CLASS - 1) state_in = ST_IDLE;
                  else cls_in = cls_ff + 1'b1;
               end else begin
                  pt_in = pt_ff + 1'b1;
               end
            end else begin
               state_in = ST_STAMP_WAIT;
            end
         end
         ST_STAMP_WAIT: state_in = ST_STAMP_WR;
         ST_STAMP_WR: begin
            mem_we = 1'b1;
            state_in = ST_STAMP_RD;
            if (pt_ff >= npts) begin
               pt_in = '0;
               if (32'(cls_ff) == NUM_CLASS - 1) state_in = ST_IDLE;
               else cls_in = cls_ff + 1'b1;
            end else begin
               pt_in = pt_ff + 1'b1;
            end
         end
         ST_READ_WAIT: state_in = ST_READ_OUT;
         ST_READ_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the point so the weight stays aligned in the blend stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cls_ff <= cls_in; pt_ff <= pt_in; clr_ff <= clr_in;
      addr_ff <= addr_in; oob_ff <= oob_in;
      if (state_ff == ST_READ_WAIT) rdpix_ff <= mem_rdata;
      if (state_ff == ST_IDLE && start) begin
         cx_ff <= req_x_pos;
         cy_ff <= req_y_pos;
         sel_ff <= 4'(req_large_dot) * 4'd6 + 4'(scale_ff);
         sa_ff <= req_opacity;
         sr_ff <= 8'((16'(red_ff) * 16'(req_opacity)) >> 8);
         sg_ff <= 8'((16'(green_ff) * 16'(req_opacity)) >> 8);
         sb_ff <= 8'((16'(blue_ff) * 16'(req_opacity)) >> 8);
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_READ_OUT);
   assign rsp_pixel_word = oob_ff ? 32'd0 : rdpix_ff;

   a_rsp_after_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_READ_WAIT) else $error("rsp without read");
   a_wr_not_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> busy) else $error("write while idle");
   a_stamp_wr_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STAMP_WR |-> $past(state_ff) == ST_STAMP_WAIT)
      else $error("write without read");
endmodule
